>>> rtl/ftfp_pkg.sv
`timescale 1ns / 1ps

package ftfp_pkg;

    // Field and register widths.
    localparam int TS_W       = 63;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int IV_HIST_W  = 40;
    localparam int UCOUNT_W   = 4;
    localparam int ALU_W      = 64;

    // Defaults for the top-level parameters.
    localparam int HISTORY_DEPTH_DEF = 4;
    localparam int MAX_STEPS_DEF     = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SNAP_TOLERANCE = 2'd2;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] FRAME_PERIOD_RST   = 32'd166667;
    localparam logic [CFG_W-1:0] REFRESH_PERIOD_RST = 32'd166667;
    localparam logic [CFG_W-1:0] SNAP_TOLERANCE_RST = 32'd2000;

    // Snap target codes, tried in this order.
    localparam int TGT_W = 3;
    localparam logic [TGT_W-1:0] TGT_1X   = 3'd0;
    localparam logic [TGT_W-1:0] TGT_2X   = 3'd1;
    localparam logic [TGT_W-1:0] TGT_3X   = 3'd2;
    localparam logic [TGT_W-1:0] TGT_4X   = 3'd3;
    localparam logic [TGT_W-1:0] TGT_HALF = 3'd4;

    localparam int TARGET_W = CFG_W + 2;

endpackage

>>> rtl/fixed_timestep_frame_pacer_unit.sv
`timescale 1ns / 1ps

// Fixed-timestep frame pacer. Each input transfer carries one reading of a
// free-running counter, taken once per display frame; each output transfer
// tells how many fixed update steps of frame_period ticks are due, the
// smoothed frame interval, and whether the frame resynchronized the pacer
// (always true on the first frame after reset, and whenever the accumulator
// runs past MAX_STEPS frame periods). The interval is clamped, snapped to
// 1x, 2x, 3x, 4x or half of refresh_period when it lies closer than
// snap_tolerance, averaged over HISTORY_DEPTH frames and accumulated. Most
// arithmetic runs through one shared 64-bit adder/subtractor stepped by a
// small sequencer, and the input is stalled while an item is worked on:
// it steps through the difference and clamp, a distance check per snap
// target tried, the history update, the average (a shift for a power-of-two
// HISTORY_DEPTH, else a bit-serial divide), accumulate and limit check,
// the counting loop over the update steps, and the load of the result.
// The result sits in an output register, so the next timestamp is
// accepted while the previous result still waits. Configuration registers
// are written through a separate port that is always ready and should be
// written only while the pacer is idle; a frame_period of zero acts as one.
module fixed_timestep_frame_pacer_unit #(
    parameter int HISTORY_DEPTH = ftfp_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_STEPS     = ftfp_pkg::MAX_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ftfp_pkg::TS_W-1:0]        timestamp,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ftfp_pkg::UCOUNT_W-1:0]    update_count,
    output logic                             did_update,
    output logic [ftfp_pkg::IV_HIST_W-1:0]   smoothed_interval,
    output logic                             resynced,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ftfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ftfp_pkg::CFG_W-1:0]       cfg_data
);

    localparam int TS_W     = ftfp_pkg::TS_W;
    localparam int CFG_W    = ftfp_pkg::CFG_W;
    localparam int HW       = ftfp_pkg::IV_HIST_W;
    localparam int ALU_W    = ftfp_pkg::ALU_W;
    localparam int TARGET_W = ftfp_pkg::TARGET_W;
    localparam int TGT_W    = ftfp_pkg::TGT_W;

    localparam int LOG2_D   = $clog2(HISTORY_DEPTH);
    localparam bit IS_POW2  = ((1 << LOG2_D) == HISTORY_DEPTH);
    localparam int SUM_W    = HW + LOG2_D;
    localparam int DCNT_W   = $clog2(SUM_W + 1);
    localparam int REM_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int REMS_W   = REM_W + 1;
    localparam int CNT_W    = $clog2(MAX_STEPS + 1);
    localparam int LIM_W    = CFG_W + CNT_W;
    localparam int KMAX     = (MAX_STEPS > HISTORY_DEPTH) ? MAX_STEPS : HISTORY_DEPTH;
    localparam int K_W      = $clog2(KMAX + 1);
    localparam int PROD_W   = CFG_W + K_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIFF   = 4'd1;
    localparam logic [3:0] S_CLAMP  = 4'd2;
    localparam logic [3:0] S_SNAP_A = 4'd3;
    localparam logic [3:0] S_SNAP_B = 4'd4;
    localparam logic [3:0] S_HIST_A = 4'd5;
    localparam logic [3:0] S_HIST_B = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_ACC    = 4'd8;
    localparam logic [3:0] S_CHECK  = 4'd9;
    localparam logic [3:0] S_COUNT  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    // Configuration registers.
    logic [CFG_W-1:0] frame_period_reg;
    logic [CFG_W-1:0] refresh_period_reg;
    logic [CFG_W-1:0] snap_tolerance_reg;

    // Sequencer and datapath registers.
    logic [3:0]          state_reg, state_next;
    logic [TS_W-1:0]     ts_reg, ts_next;
    logic [TS_W-1:0]     last_reg, last_next;
    logic [TS_W-1:0]     iv_reg, iv_next;
    logic [LIM_W-1:0]    limit_reg, limit_next;
    logic [TGT_W-1:0]    tidx_reg, tidx_next;
    logic [TARGET_W-1:0] target_reg, target_next;
    logic [TS_W-1:0]     d1_reg, d1_next;
    logic                b1_reg, b1_next;
    logic [HW-1:0]       hist_reg [HISTORY_DEPTH];
    logic [HW-1:0]       hist_next [HISTORY_DEPTH];
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SUM_W-1:0]    dq_reg, dq_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [HW-1:0]       avg_reg, avg_next;
    logic [HW-1:0]       acc_reg, acc_next;
    logic                pend_reg, pend_next;
    logic                rsy_reg, rsy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // Output register.
    logic                    ovalid_reg, ovalid_next;
    logic [CNT_W-1:0]        ocnt_reg, ocnt_next;
    logic [HW-1:0]           oavg_reg, oavg_next;
    logic                    orsy_reg, orsy_next;

    // Shared arithmetic unit.
    logic [ALU_W-1:0] alu_a, alu_b, alu_out;
    logic             alu_sub, alu_borrow;
    logic [ALU_W:0]   alu_res;

    // Multiplier for the period limit and the history sum after a resync.
    logic [K_W-1:0]    mul_k;
    logic [PROD_W-1:0] mul_prod;

    logic [CFG_W-1:0] fp_eff;
    logic [TS_W-1:0]  abs_v;
    logic             snap_hit;
    logic [REMS_W-1:0] rem_sh;
    logic              qbit;
    logic              in_take, out_take, out_load;

    function automatic logic [TARGET_W-1:0] target_of(input logic [TGT_W-1:0] idx,
                                                     input logic [CFG_W-1:0] r);
        logic [TARGET_W-1:0] rx;
        rx = TARGET_W'(r);
        unique case (idx)
            ftfp_pkg::TGT_1X: target_of = rx;
            ftfp_pkg::TGT_2X: target_of = rx << 1;
            ftfp_pkg::TGT_3X: target_of = rx + (rx << 1);
            ftfp_pkg::TGT_4X: target_of = rx << 2;
            default:          target_of = (rx + TARGET_W'(1)) >> 1;
        endcase
    endfunction

    assign fp_eff   = (frame_period_reg == '0) ? CFG_W'(1) : frame_period_reg;
    assign mul_prod = PROD_W'(fp_eff) * PROD_W'(mul_k);

    assign alu_res    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                        + {{ALU_W{1'b0}}, alu_sub};
    assign alu_out    = alu_res[ALU_W-1:0];
    assign alu_borrow = alu_sub & ~alu_res[ALU_W];

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = ovalid_reg && !out_stall;
    assign out_load  = (state_reg == S_DONE) && (!ovalid_reg || !out_stall);
    assign cfg_ready = 1'b1;

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        mul_k   = K_W'(MAX_STEPS);
        unique case (state_reg)
            S_DIFF:
            begin
                alu_a   = ALU_W'(ts_reg);
                alu_b   = ALU_W'(last_reg);
                alu_sub = 1'b1;
            end
            S_CLAMP:
            begin
                alu_a   = ALU_W'(limit_reg);
                alu_b   = ALU_W'(iv_reg);
                alu_sub = 1'b1;
            end
            S_SNAP_A:
            begin
                alu_a   = ALU_W'(iv_reg);
                alu_b   = ALU_W'(target_reg);
                alu_sub = 1'b1;
            end
            S_SNAP_B:
            begin
                alu_a   = ALU_W'(target_reg);
                alu_b   = ALU_W'(iv_reg);
                alu_sub = 1'b1;
            end
            S_HIST_A:
            begin
                alu_a = ALU_W'(sum_reg);
                alu_b = ALU_W'(iv_reg[HW-1:0]);
            end
            S_HIST_B:
            begin
                alu_a   = ALU_W'(sum_reg);
                alu_b   = ALU_W'(hist_reg[0]);
                alu_sub = 1'b1;
            end
            S_ACC:
            begin
                alu_a = ALU_W'(acc_reg);
                alu_b = ALU_W'(avg_reg);
            end
            S_CHECK:
            begin
                alu_a   = ALU_W'(limit_reg);
                alu_b   = ALU_W'(acc_reg);
                alu_sub = 1'b1;
                mul_k   = K_W'(HISTORY_DEPTH);
            end
            S_COUNT:
            begin
                alu_a   = ALU_W'(acc_reg);
                alu_b   = ALU_W'(fp_eff);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // The snap distance is whichever of the two differences did not borrow.
    assign abs_v    = b1_reg ? alu_out[TS_W-1:0] : d1_reg;
    assign snap_hit = (abs_v < TS_W'(snap_tolerance_reg));

    // One step of the bit-serial divide by the history depth.
    assign rem_sh = {rem_reg, dq_reg[SUM_W-1]};
    assign qbit   = (rem_sh >= REMS_W'(HISTORY_DEPTH));

    always_comb
    begin
        state_next  = state_reg;
        ts_next     = ts_reg;
        last_next   = last_reg;
        iv_next     = iv_reg;
        limit_next  = limit_reg;
        tidx_next   = tidx_reg;
        target_next = target_reg;
        d1_next     = d1_reg;
        b1_next     = b1_reg;
        hist_next   = hist_reg;
        sum_next    = sum_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        avg_next    = avg_reg;
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        rsy_next    = rsy_reg;
        cnt_next    = cnt_reg;
        ovalid_next = out_take ? 1'b0 : ovalid_reg;
        ocnt_next   = ocnt_reg;
        oavg_next   = oavg_reg;
        orsy_next   = orsy_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    ts_next    = timestamp;
                    rsy_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                // A timestamp that went backwards gives a zero interval.
                iv_next    = alu_borrow ? '0 : alu_out[TS_W-1:0];
                last_next  = ts_reg;
                limit_next = LIM_W'(mul_prod);
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (alu_borrow)
                begin
                    iv_next = TS_W'(fp_eff);
                end
                tidx_next   = ftfp_pkg::TGT_1X;
                target_next = target_of(ftfp_pkg::TGT_1X, refresh_period_reg);
                state_next  = S_SNAP_A;
            end
            S_SNAP_A:
            begin
                d1_next    = alu_out[TS_W-1:0];
                b1_next    = alu_borrow;
                state_next = S_SNAP_B;
            end
            S_SNAP_B:
            begin
                if (snap_hit)
                begin
                    iv_next    = TS_W'(target_reg);
                    state_next = S_HIST_A;
                end
                else if (tidx_reg == ftfp_pkg::TGT_HALF)
                begin
                    state_next = S_HIST_A;
                end
                else
                begin
                    tidx_next   = tidx_reg + TGT_W'(1);
                    target_next = target_of(tidx_reg + TGT_W'(1), refresh_period_reg);
                    state_next  = S_SNAP_A;
                end
            end
            S_HIST_A:
            begin
                sum_next   = alu_out[SUM_W-1:0];
                state_next = S_HIST_B;
            end
            S_HIST_B:
            begin
                // The running sum drops the oldest entry as the history shifts.
                sum_next = alu_out[SUM_W-1:0];
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                begin
                    hist_next[i] = hist_reg[i + 1];
                end
                hist_next[HISTORY_DEPTH - 1] = iv_reg[HW-1:0];
                dq_next    = alu_out[SUM_W-1:0];
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (IS_POW2)
                begin
                    avg_next   = sum_reg[SUM_W-1:LOG2_D];
                    state_next = S_ACC;
                end
                else
                begin
                    rem_next  = qbit ? REM_W'(rem_sh - REMS_W'(HISTORY_DEPTH))
                                     : REM_W'(rem_sh);
                    dq_next   = {dq_reg[SUM_W-2:0], qbit};
                    dcnt_next = dcnt_reg + DCNT_W'(1);
                    if (dcnt_reg == DCNT_W'(SUM_W - 1))
                    begin
                        avg_next   = dq_next[HW-1:0];
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC:
            begin
                acc_next   = alu_out[HW-1:0];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (pend_reg || alu_borrow)
                begin
                    acc_next  = '0;
                    avg_next  = HW'(fp_eff);
                    pend_next = 1'b0;
                    rsy_next  = 1'b1;
                    sum_next  = SUM_W'(mul_prod);
                    for (int i = 0; i < HISTORY_DEPTH; i++)
                    begin
                        hist_next[i] = HW'(fp_eff);
                    end
                end
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                if (alu_borrow)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    acc_next = alu_out[HW-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    ovalid_next = 1'b1;
                    ocnt_next   = cnt_reg;
                    oavg_next   = avg_reg;
                    orsy_next   = rsy_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_period_reg   <= ftfp_pkg::FRAME_PERIOD_RST;
            refresh_period_reg <= ftfp_pkg::REFRESH_PERIOD_RST;
            snap_tolerance_reg <= ftfp_pkg::SNAP_TOLERANCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ftfp_pkg::REG_FRAME_PERIOD:   frame_period_reg   <= cfg_data;
                ftfp_pkg::REG_REFRESH_PERIOD: refresh_period_reg <= cfg_data;
                ftfp_pkg::REG_SNAP_TOLERANCE: snap_tolerance_reg <= cfg_data;
                default:                      frame_period_reg   <= frame_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            last_reg   <= '0;
            acc_reg    <= '0;
            pend_reg   <= 1'b1;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            sum_reg    <= sum_next;
            ovalid_reg <= ovalid_next;
            hist_reg   <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg     <= ts_next;
        iv_reg     <= iv_next;
        limit_reg  <= limit_next;
        tidx_reg   <= tidx_next;
        target_reg <= target_next;
        d1_reg     <= d1_next;
        b1_reg     <= b1_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        avg_reg    <= avg_next;
        rsy_reg    <= rsy_next;
        cnt_reg    <= cnt_next;
        ocnt_reg   <= ocnt_next;
        oavg_reg   <= oavg_next;
        orsy_reg   <= orsy_next;
    end

    assign out_valid         = ovalid_reg;
    assign update_count      = ftfp_pkg::UCOUNT_W'(ocnt_reg);
    assign did_update        = (ocnt_reg != '0);
    assign smoothed_interval = oavg_reg;
    assign resynced          = orsy_reg;

    // The counting loop leaves less than one frame period behind.
    a_acc_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (acc_reg < HW'(fp_eff)))
        else $error("accumulator not reduced below one frame period");

    // The step count never passes the configured maximum.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (cnt_reg <= CNT_W'(MAX_STEPS)))
        else $error("update step count beyond the maximum");

    // A resync empties the accumulator and reports the frame period.
    a_resync_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && orsy_reg) |-> (!did_update && (oavg_reg == HW'(fp_eff))))
        else $error("resync result carries steps or a wrong interval");

endmodule
